// ===== design/lcps_pkg.sv =====
// Shared constants, register indexes and types of the laser channel power sequencer.
package lcps_pkg;

  localparam int unsigned CHANNELS = 2;
  localparam int unsigned CH_W     = 1;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned CUR_W    = 8;

  localparam logic [DELAY_W-1:0] ON_DELAY_RST  = 16'd2000;
  localparam logic [DELAY_W-1:0] OFF_DELAY_RST = 16'd200;

  typedef enum logic [0:0] {
    CfgOnDelay  = 1'b0,
    CfgOffDelay = 1'b1
  } cfg_reg_e;

  // Per-channel state, one RAM entry.
  typedef struct packed {
    logic              pending_on;
    logic              off_pending;
    logic [TIME_W-1:0] on_start;
    logic [TIME_W-1:0] off_start;
    logic              switch_closed;
    logic              power_on;
    logic [CUR_W-1:0]  last_current;
  } chan_state_t;

  localparam int unsigned STATE_W = $bits(chan_state_t);

  // One accepted poll word.
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] now_ms;
    logic              enable_request;
    logic              fault_present;
    logic              setup_done;
    logic [CUR_W-1:0]  current_setpoint;
  } poll_t;

  // One result word, channel excepted.
  typedef struct packed {
    logic             power_enable;
    logic             switch_closed;
    logic             current_write;
    logic [CUR_W-1:0] current_value;
  } result_t;

endpackage

// ===== design/laser_channel_power_sequencer.sv =====
// Top level of the laser channel power sequencer: poll pipeline, state RAM and output register.
//
// The block takes one poll word per cycle while not stalled and returns one result word per
// poll, in order. Accepting a poll reads its channel's state from a RAM of CHANNELS entries;
// advancing the update stage updates that state, writes it back and loads the output register.
// The last written entry is kept in a bypass register, so polls of the same channel in
// consecutive cycles see each other's updates without a bubble. Entries not yet written read as
// the reset state, tracked by one valid flop per channel. The delay registers reset to 2000 ms
// and 200 ms; the user must write them only while the block is idle, which it does not enforce.
module laser_channel_power_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [lcps_pkg::DELAY_W-1:0]     cfg_data_i,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lcps_pkg::CH_W-1:0]        channel_i,
  input  logic [lcps_pkg::TIME_W-1:0]      now_ms_i,
  input  logic                             enable_request_i,
  input  logic                             fault_present_i,
  input  logic                             setup_done_i,
  input  logic [lcps_pkg::CUR_W-1:0]       current_setpoint_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lcps_pkg::CH_W-1:0]        out_channel_o,
  output logic                             power_enable_o,
  output logic                             switch_closed_o,
  output logic                             current_write_o,
  output logic [lcps_pkg::CUR_W-1:0]       current_value_o
);

  logic [lcps_pkg::DELAY_W-1:0] on_delay_q;
  logic [lcps_pkg::DELAY_W-1:0] off_delay_q;

  logic                         s1_valid_q;
  lcps_pkg::poll_t              s1_poll_q;
  logic                         s1_advance;
  logic                         in_accept;
  logic                         in_range;

  logic [lcps_pkg::CHANNELS-1:0] entry_valid_q;
  logic                          fwd_valid_q;
  logic [lcps_pkg::CH_W-1:0]     fwd_ch_q;
  lcps_pkg::chan_state_t         fwd_state_q;

  logic [lcps_pkg::STATE_W-1:0]  ram_rdata;
  lcps_pkg::chan_state_t         cur_state;
  lcps_pkg::chan_state_t         new_state;
  lcps_pkg::result_t             new_result;
  logic                          ram_we;

  logic                          out_valid_q;
  logic [lcps_pkg::CH_W-1:0]     out_ch_q;
  lcps_pkg::result_t             out_res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_delay_q  <= lcps_pkg::ON_DELAY_RST;
      off_delay_q <= lcps_pkg::OFF_DELAY_RST;
    end else if (cfg_we_i) begin
      case (lcps_pkg::cfg_reg_e'(cfg_idx_i))
        lcps_pkg::CfgOnDelay:  on_delay_q  <= cfg_data_i;
        lcps_pkg::CfgOffDelay: off_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The update stage moves on whenever the output register is free or being emptied.
  assign s1_advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = 32'(channel_i) < lcps_pkg::CHANNELS;

  // An empty read stage takes a new word even while the output register is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_accept && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_poll_q.channel          <= channel_i;
      s1_poll_q.now_ms           <= now_ms_i;
      s1_poll_q.enable_request   <= enable_request_i;
      s1_poll_q.fault_present    <= fault_present_i;
      s1_poll_q.setup_done       <= setup_done_i;
      s1_poll_q.current_setpoint <= current_setpoint_i;
    end
  end

  lcps_ram #(
    .Width (lcps_pkg::STATE_W),
    .Depth (lcps_pkg::CHANNELS),
    .AddrW (lcps_pkg::CH_W)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_poll_q.channel),
    .wdata_i (new_state),
    .re_i    (in_accept),
    .raddr_i (channel_i),
    .rdata_o (ram_rdata)
  );

  // The bypass always holds the most recent write, so it wins over the RAM for its channel.
  always_comb begin
    if (fwd_valid_q && (fwd_ch_q == s1_poll_q.channel)) begin
      cur_state = fwd_state_q;
    end else if (entry_valid_q[s1_poll_q.channel]) begin
      cur_state = lcps_pkg::chan_state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  lcps_update u_update (
    .state_i     (cur_state),
    .poll_i      (s1_poll_q),
    .on_delay_i  (on_delay_q),
    .off_delay_i (off_delay_q),
    .state_o     (new_state),
    .result_o    (new_result)
  );

  assign ram_we = s1_valid_q && s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      fwd_valid_q   <= 1'b0;
    end else if (ram_we) begin
      entry_valid_q[s1_poll_q.channel] <= 1'b1;
      fwd_valid_q                      <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_ch_q    <= s1_poll_q.channel;
      fwd_state_q <= new_state;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      out_ch_q  <= s1_poll_q.channel;
      out_res_q <= new_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_ch_q;
  assign power_enable_o  = out_res_q.power_enable;
  assign switch_closed_o = out_res_q.switch_closed;
  assign current_write_o = out_res_q.current_write;
  assign current_value_o = out_res_q.current_value;

endmodule

// ===== design/lcps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lcps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lcps_update.sv =====
// Next-state and result logic for one poll of one channel.
module lcps_update (
  input  lcps_pkg::chan_state_t              state_i,
  input  lcps_pkg::poll_t                    poll_i,
  input  logic [lcps_pkg::DELAY_W-1:0]       on_delay_i,
  input  logic [lcps_pkg::DELAY_W-1:0]       off_delay_i,
  output lcps_pkg::chan_state_t              state_o,
  output lcps_pkg::result_t                  result_o
);

  logic                          want_on;
  logic [lcps_pkg::TIME_W-1:0]   on_elapsed;
  logic [lcps_pkg::TIME_W-1:0]   off_elapsed;
  logic                          on_done;
  logic                          off_done;
  lcps_pkg::chan_state_t         st;
  lcps_pkg::result_t             res;

  assign want_on = poll_i.enable_request && !poll_i.fault_present && poll_i.setup_done &&
                   (poll_i.current_setpoint != '0);

  // Wrapping subtraction keeps elapsed time right across timestamp rollover.
  assign on_elapsed  = poll_i.now_ms - state_i.on_start;
  assign off_elapsed = poll_i.now_ms - state_i.off_start;
  assign on_done     = on_elapsed >= {{(lcps_pkg::TIME_W - lcps_pkg::DELAY_W){1'b0}}, on_delay_i};
  assign off_done    = off_elapsed >= {{(lcps_pkg::TIME_W - lcps_pkg::DELAY_W){1'b0}}, off_delay_i};

  always_comb begin
    st  = state_i;
    res = '0;

    // The zero write looks at the switch level before this poll moves it.
    if (want_on) begin
      if (state_i.last_current != poll_i.current_setpoint) begin
        st.last_current   = poll_i.current_setpoint;
        res.current_write = 1'b1;
        res.current_value = poll_i.current_setpoint;
      end
    end else if ((state_i.last_current != '0) && !state_i.switch_closed) begin
      st.last_current   = '0;
      res.current_write = 1'b1;
    end

    if (want_on) begin
      if (state_i.pending_on) begin
        if (on_done) begin
          st.switch_closed = 1'b1;
          st.pending_on    = 1'b0;
        end
      end else begin
        st.power_on = 1'b1;
        if (!state_i.switch_closed) begin
          st.pending_on = 1'b1;
          st.on_start   = poll_i.now_ms;
        end
        st.off_pending = 1'b0;
      end
    end else begin
      if (state_i.off_pending) begin
        if (off_done) begin
          st.switch_closed = 1'b0;
          st.off_pending   = 1'b0;
        end
      end else begin
        st.power_on = 1'b0;
        if (state_i.switch_closed) begin
          st.off_pending = 1'b1;
          st.off_start   = poll_i.now_ms;
        end
        st.pending_on = 1'b0;
      end
    end

    res.power_enable  = st.power_on;
    res.switch_closed = st.switch_closed;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

// ===== bench/laser_channel_power_sequencer_tb.sv =====
// Self-checking testbench of the laser channel power sequencer: directed table, random polls.
module laser_channel_power_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected word: the polled channel and its result fields.
  typedef struct packed {
    logic [lcps_pkg::CH_W-1:0] ch;
    lcps_pkg::result_t         res;
  } chan_levels_t;

  // One directed row: a poll, and the result typed in when it is obvious.
  typedef struct packed {
    lcps_pkg::poll_t   poll;
    logic              typed;
    lcps_pkg::result_t res;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 22;
  localparam int unsigned PHASES   = 7;
  localparam int unsigned PHASE_POLLS = 140;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [0:0]                    cfg_idx;
  logic [lcps_pkg::DELAY_W-1:0]  cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [lcps_pkg::CH_W-1:0]     channel;
  logic [lcps_pkg::TIME_W-1:0]   now_ms;
  logic                          enable_request;
  logic                          fault_present;
  logic                          setup_done;
  logic [lcps_pkg::CUR_W-1:0]    current_setpoint;
  logic                          out_valid;
  logic                          out_stall;
  logic [lcps_pkg::CH_W-1:0]     out_channel;
  logic                          power_enable;
  logic                          switch_closed;
  logic                          current_write;
  logic [lcps_pkg::CUR_W-1:0]    current_value;

  laser_channel_power_sequencer u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .channel_i          (channel),
    .now_ms_i           (now_ms),
    .enable_request_i   (enable_request),
    .fault_present_i    (fault_present),
    .setup_done_i       (setup_done),
    .current_setpoint_i (current_setpoint),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_channel_o      (out_channel),
    .power_enable_o     (power_enable),
    .switch_closed_o    (switch_closed),
    .current_write_o    (current_write),
    .current_value_o    (current_value)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow copy of the delay registers and of every channel's sequencing state.
  logic [lcps_pkg::DELAY_W-1:0] on_delay;
  logic [lcps_pkg::DELAY_W-1:0] off_delay;
  logic                         on_waiting  [lcps_pkg::CHANNELS];
  logic                         off_waiting [lcps_pkg::CHANNELS];
  logic [lcps_pkg::TIME_W-1:0]  on_since    [lcps_pkg::CHANNELS];
  logic [lcps_pkg::TIME_W-1:0]  off_since   [lcps_pkg::CHANNELS];
  logic                         sw_closed   [lcps_pkg::CHANNELS];
  logic                         pwr_on      [lcps_pkg::CHANNELS];
  logic [lcps_pkg::CUR_W-1:0]   dac_last    [lcps_pkg::CHANNELS];

  chan_levels_t due_levels[$];
  chan_levels_t head;
  int unsigned  errors = 0;
  int unsigned  polls_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  dac_writes = 0;
  int unsigned  closings = 0;
  bit           quiet = 1'b0;
  int unsigned  stall_left = 0;

  // Applies one poll to the shadow state and returns the levels it must produce.
  function automatic chan_levels_t step_channel(lcps_pkg::poll_t p);
    chan_levels_t o;
    int           c;
    logic         go;
    logic [lcps_pkg::TIME_W-1:0] elapsed;
    c = int'(p.channel);
    o = '0;
    o.ch = p.channel;
    go = p.enable_request && !p.fault_present && p.setup_done && (p.current_setpoint != '0);
    if (go) begin
      if (dac_last[c] != p.current_setpoint) begin
        dac_last[c] = p.current_setpoint;
        o.res.current_write = 1'b1;
        o.res.current_value = p.current_setpoint;
      end
    end else if (dac_last[c] != '0 && !sw_closed[c]) begin
      dac_last[c] = '0;
      o.res.current_write = 1'b1;
    end
    if (go) begin
      if (on_waiting[c]) begin
        // A wait already running in this direction only checks its deadline.
        elapsed = p.now_ms - on_since[c];
        if (elapsed >= lcps_pkg::TIME_W'(on_delay)) begin
          sw_closed[c] = 1'b1;
          on_waiting[c] = 1'b0;
        end
      end else begin
        pwr_on[c] = 1'b1;
        if (!sw_closed[c]) begin
          on_waiting[c] = 1'b1;
          on_since[c] = p.now_ms;
        end
        off_waiting[c] = 1'b0;
      end
    end else begin
      if (off_waiting[c]) begin
        elapsed = p.now_ms - off_since[c];
        if (elapsed >= lcps_pkg::TIME_W'(off_delay)) begin
          sw_closed[c] = 1'b0;
          off_waiting[c] = 1'b0;
        end
      end else begin
        pwr_on[c] = 1'b0;
        if (sw_closed[c]) begin
          off_waiting[c] = 1'b1;
          off_since[c] = p.now_ms;
        end
        on_waiting[c] = 1'b0;
      end
    end
    o.res.power_enable = pwr_on[c];
    o.res.switch_closed = sw_closed[c];
    return o;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Offers one poll word and holds it until the block takes it.
  task automatic offer(lcps_pkg::poll_t p, logic typed, lcps_pkg::result_t typed_res);
    chan_levels_t o;
    in_valid         <= 1'b1;
    channel          <= p.channel;
    now_ms           <= p.now_ms;
    enable_request   <= p.enable_request;
    fault_present    <= p.fault_present;
    setup_done       <= p.setup_done;
    current_setpoint <= p.current_setpoint;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = step_channel(p);
    if (typed) o.res = typed_res;
    due_levels.push_back(o);
    polls_sent++;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay(lcps_pkg::cfg_reg_e idx, logic [lcps_pkg::DELAY_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == lcps_pkg::CfgOnDelay) on_delay = value;
    else off_delay = value;
  endtask

  // Receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_levels.size() == 0) begin
        $error("result word on channel %0d with nothing expected", out_channel);
        errors++;
      end else begin
        head = due_levels.pop_front();
        check_field("out_channel", 8'(head.ch), 8'(out_channel));
        check_field("power_enable", 8'(head.res.power_enable), 8'(power_enable));
        check_field("switch_closed", 8'(head.res.switch_closed), 8'(switch_closed));
        check_field("current_write", 8'(head.res.current_write), 8'(current_write));
        check_field("current_value", head.res.current_value, current_value);
        words_checked++;
        if (head.res.current_write) dac_writes++;
        if (head.res.switch_closed) closings++;
      end
    end
  end

  // Defaults after reset are 2000 ms on and 200 ms off.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{1'b0, 32'd0,          1'b1, 1'b0, 1'b1, 8'd255}, 1'b1, '{1'b1, 1'b0, 1'b1, 8'd255}},
    '{'{1'b0, 32'd1999,       1'b1, 1'b0, 1'b1, 8'd255}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
    '{'{1'b0, 32'd2000,       1'b1, 1'b0, 1'b1, 8'd255}, 1'b1, '{1'b1, 1'b1, 1'b0, 8'd0}},
    '{'{1'b0, 32'd2001,       1'b1, 1'b0, 1'b1, 8'd1},   1'b1, '{1'b1, 1'b1, 1'b1, 8'd1}},
    '{'{1'b0, 32'd2002,       1'b1, 1'b1, 1'b1, 8'd1},   1'b1, '{1'b0, 1'b1, 1'b0, 8'd0}},
    '{'{1'b0, 32'd2201,       1'b1, 1'b1, 1'b1, 8'd1},   1'b1, '{1'b0, 1'b1, 1'b0, 8'd0}},
    '{'{1'b0, 32'd2202,       1'b1, 1'b1, 1'b1, 8'd1},   1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}},
    '{'{1'b0, 32'd2203,       1'b1, 1'b1, 1'b1, 8'd1},   1'b1, '{1'b0, 1'b0, 1'b1, 8'd0}},
    '{'{1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 8'd0},   1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}},
    '{'{1'b1, 32'hFFFF_FF00,  1'b1, 1'b0, 1'b1, 8'd128}, 1'b1, '{1'b1, 1'b0, 1'b1, 8'd128}},
    '{'{1'b1, 32'h0000_06CF,  1'b1, 1'b0, 1'b1, 8'd128}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
    '{'{1'b1, 32'h0000_06D0,  1'b1, 1'b0, 1'b1, 8'd128}, 1'b1, '{1'b1, 1'b1, 1'b0, 8'd0}},
    '{'{1'b1, 32'h0000_06D1,  1'b1, 1'b0, 1'b1, 8'd0},   1'b1, '{1'b0, 1'b1, 1'b0, 8'd0}},
    '{'{1'b1, 32'h0000_06D2,  1'b1, 1'b0, 1'b1, 8'd128}, 1'b1, '{1'b1, 1'b1, 1'b0, 8'd0}},
    '{'{1'b1, 32'h0000_06D3,  1'b0, 1'b0, 1'b1, 8'd128}, 1'b1, '{1'b0, 1'b1, 1'b0, 8'd0}},
    '{'{1'b1, 32'h0000_06D4,  1'b1, 1'b0, 1'b1, 8'd200}, 1'b0, '0},
    '{'{1'b0, 32'h7FFF_FFFF,  1'b1, 1'b0, 1'b0, 8'h55},  1'b0, '0},
    '{'{1'b0, 32'h8000_0000,  1'b1, 1'b0, 1'b1, 8'hAA},  1'b0, '0},
    '{'{1'b0, 32'h8000_0001,  1'b0, 1'b0, 1'b1, 8'hAA},  1'b0, '0},
    '{'{1'b1, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, 8'd255}, 1'b0, '0},
    '{'{1'b1, 32'd0,          1'b0, 1'b0, 1'b0, 8'd0},   1'b0, '0},
    '{'{1'b0, 32'h1234_5678,  1'b1, 1'b0, 1'b1, 8'h0F},  1'b0, '0}
  };

  logic [lcps_pkg::DELAY_W-1:0] on_plan  [PHASES];
  logic [lcps_pkg::DELAY_W-1:0] off_plan [PHASES];
  logic                         want_on  [lcps_pkg::CHANNELS];
  logic [lcps_pkg::CUR_W-1:0]   level    [lcps_pkg::CHANNELS];
  logic [lcps_pkg::TIME_W-1:0]  clock_ms;
  int unsigned                  step_max;
  lcps_pkg::poll_t              p;

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = lcps_pkg::CfgOnDelay;
    cfg_data         = '0;
    in_valid         = 1'b0;
    channel          = '0;
    now_ms           = '0;
    enable_request   = 1'b0;
    fault_present    = 1'b0;
    setup_done       = 1'b0;
    current_setpoint = '0;
    out_stall        = 1'b0;
    on_delay         = lcps_pkg::ON_DELAY_RST;
    off_delay        = lcps_pkg::OFF_DELAY_RST;
    for (int c = 0; c < lcps_pkg::CHANNELS; c++) begin
      on_waiting[c]  = 1'b0;
      off_waiting[c] = 1'b0;
      on_since[c]    = '0;
      off_since[c]   = '0;
      sw_closed[c]   = 1'b0;
      pwr_on[c]      = 1'b0;
      dac_last[c]    = '0;
      want_on[c]     = 1'b0;
      level[c]       = 8'd1;
    end
    on_plan  = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, lcps_pkg::ON_DELAY_RST};
    off_plan = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, lcps_pkg::OFF_DELAY_RST};
    on_plan[2]  = lcps_pkg::DELAY_W'($urandom_range(1, 20));
    off_plan[2] = lcps_pkg::DELAY_W'($urandom_range(1, 20));
    on_plan[5]  = lcps_pkg::DELAY_W'($urandom_range(0, 16'hFFFF));
    off_plan[5] = lcps_pkg::DELAY_W'($urandom_range(0, 16'hFFFF));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      offer(directed_rows[i].poll, directed_rows[i].typed, directed_rows[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Delay registers change only with the pipeline empty.
      drain();
      write_delay(lcps_pkg::CfgOnDelay, on_plan[ph]);
      write_delay(lcps_pkg::CfgOffDelay, off_plan[ph]);
      quiet = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      step_max = ((on_delay > off_delay) ? on_delay : off_delay) / 6 + 2;
      clock_ms = (ph == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 100000) : $urandom;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        p.channel = lcps_pkg::CH_W'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 8) begin
          p.now_ms           = $urandom;
          p.enable_request   = 1'($urandom_range(0, 1));
          p.fault_present    = 1'($urandom_range(0, 1));
          p.setup_done       = 1'($urandom_range(0, 1));
          p.current_setpoint = lcps_pkg::CUR_W'($urandom_range(0, 255));
        end else begin
          if ($urandom_range(0, 9) == 0) want_on[p.channel] = !want_on[p.channel];
          if ($urandom_range(0, 7) == 0) level[p.channel] = lcps_pkg::CUR_W'($urandom_range(1, 255));
          clock_ms = clock_ms + $urandom_range(0, step_max);
          p.now_ms           = clock_ms;
          p.enable_request   = 1'b1;
          p.fault_present    = 1'b0;
          p.setup_done       = 1'b1;
          p.current_setpoint = level[p.channel];
          if (!want_on[p.channel]) begin
            case ($urandom_range(0, 3))
              0: p.enable_request = 1'b0;
              1: p.fault_present = 1'b1;
              2: p.setup_done = 1'b0;
              default: p.current_setpoint = '0;
            endcase
          end
        end
        offer(p, 1'b0, '0);
      end
    end

    drain();
    repeat (6) @(posedge clk);
    $display("%0d polls sent, %0d result words checked over %0d delay settings",
             polls_sent, words_checked, PHASES + 1);
    $display("%0d current writes and %0d closed-switch words seen", dac_writes, closings);
    if (errors == 0 && due_levels.size() == 0) begin
      $display("laser_channel_power_sequencer test passed");
    end else begin
      $display("laser_channel_power_sequencer test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("laser_channel_power_sequencer test failed");
    $finish;
  end

endmodule
